// ===== rtl/core/ray_box_nearest_hit_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Ray box nearest hit unit: assertion macros
// Clocked on i_clk; the first form is gated off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_NEAREST_HIT_UNIT_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_UNIT_DEFINES_SVH

`ifndef SYNTH
`define RBNH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RBNH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RBNH_ASSERT(lbl, prop, msg)
`define RBNH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/rbnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package rbnh_pkg;

    localparam int COORD_BITS   = 32;
    localparam int ID_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int MAG_BITS     = COORD_BITS;
    localparam int MUL_W        = COORD_BITS + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int SUM_W        = 2 * MAG_BITS;
    localparam int U_W          = 17;
    localparam int INV_W        = 33;
    localparam int DVD_W        = MAG_BITS + 16;
    localparam int DVS_W        = MAG_BITS;
    localparam int T_W          = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIST = 3'd6;

    localparam logic signed [COORD_BITS-1:0] RST_DIR_Z    = 32'sd65536;
    localparam logic signed [COORD_BITS-1:0] RST_MAX_DIST = 32'sd6553600;

    localparam logic [T_W-1:0]   T_CAP     = 64'h4000_0000_0000_0000;
    localparam logic [SUM_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [DVD_W-1:0] INV_NUM   = 48'h0001_0000_0000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic       box_rdy;
        logic       mul_en;
        logic       mul_slab;
        logic [2:0] mul_idx;
        logic       sq_clr;
        logic       sq_acc;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_start;
        logic       div_inv;
        logic [1:0] div_ax;
        logic       u_load;
        logic       inv_load;
        logic       slab_proc;
        logic [2:0] proc_idx;
        logic       fin;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic box_acc;
        logic div_done;
        logic last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/rbnh_ifs.sv =====
// ----------------------------------------------------------------------------
// rbnh channel interfaces
// Box input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rbnh_box_if #(parameter int ID_BITS = rbnh_pkg::ID_BITS_DEF);
    import rbnh_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ID_BITS-1:0]    box_id;
    t_coord                box_min_x;
    t_coord                box_min_y;
    t_coord                box_min_z;
    t_coord                box_max_x;
    t_coord                box_max_y;
    t_coord                box_max_z;
    logic                  last_box;
    modport source (output valid, box_id, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, last_box, input ready);
    modport sink   (input valid, box_id, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, last_box, output ready);
endinterface

interface rbnh_res_if #(parameter int ID_BITS = rbnh_pkg::ID_BITS_DEF);
    import rbnh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    hit_found;
    logic [ID_BITS-1:0]      hit_id;
    logic [COORD_BITS-2:0]   hit_distance;
    modport source (output valid, hit_found, hit_id, hit_distance, input ready);
    modport sink   (input valid, hit_found, hit_id, hit_distance, output ready);
endinterface

interface rbnh_cfg_if;
    import rbnh_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] reg_index;
    logic [COORD_BITS-1:0]   wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/core/ray_box_nearest_hit_unit.sv =====
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_unit
// Nearest hit of a configured ray against a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// The ray (origin, direction, max distance, signed Q16.16) is written through
// the configuration channel; every write to a known register restarts the scan
// and starts a ray setup (the squares summed on the multiplier, a 32-step
// square root, then six divisions on the shared 48-step divider) during
// which no box is taken. After setup each box is accepted, then the single
// 33x33 multiplier is issued six times (two slab distances per axis), each
// min/max update using the product in the cycle after its issue, and then
// the box is folded into the best hit. The box marked last then loads its
// result into an output register, held off while the previous result still
// waits there; once loaded, the next box can be accepted while the result
// waits, and the scan state clears.
// ----------------------------------------------------------------------------
module ray_box_nearest_hit_unit #(
    parameter int ID_BITS = rbnh_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbnh_box_if.sink    i_box,
    rbnh_res_if.source  o_res,
    rbnh_cfg_if.sink    i_cfg
);
    import rbnh_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rbnh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rbnh_dp #(
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_box   (i_box),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule

// ===== rtl/core/rbnh_div.sv =====
// ----------------------------------------------------------------------------
// rbnh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbnh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbnh_pkg::DVD_W-1:0] i_dividend,
    input  logic [rbnh_pkg::DVS_W-1:0] i_divisor,
    output logic [rbnh_pkg::DVD_W-1:0] o_quot,
    output logic                       o_done
);
    import rbnh_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   w_rem_sh;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? DVS_W'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

// ===== rtl/core/rbnh_dp.sv =====
// ----------------------------------------------------------------------------
// rbnh_dp
// Ray datapath: ray setup registers, shared multiplier, square root, divider
// and slab accumulation of near and far distances.
// ----------------------------------------------------------------------------
`include "ray_box_nearest_hit_unit_defines.svh"

module rbnh_dp #(
    parameter int ID_BITS = rbnh_pkg::ID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbnh_pkg::t_cmd i_cmd,
    output rbnh_pkg::t_sts o_sts,
    rbnh_box_if.sink       i_box,
    rbnh_res_if.source     o_res,
    rbnh_cfg_if.sink       i_cfg
);
    import rbnh_pkg::*;

    t_coord               r_org [3];
    t_coord               r_dir [3];
    t_coord               r_max;
    t_coord               r_best;
    logic [ID_BITS-1:0]   r_best_id;
    logic                 r_any;

    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_sq_n;
    logic [SUM_W-1:0]     r_sq_r;
    logic [SUM_W-1:0]     r_sq_bit;
    logic [U_W-1:0]       r_u [3];
    logic                 r_uneg [3];
    logic [INV_W-1:0]     r_inv [3];

    t_coord               r_lo [3];
    t_coord               r_hi [3];
    logic [ID_BITS-1:0]   r_id;
    logic                 r_last;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_tneg;
    logic signed [T_W-1:0] r_t1;
    logic signed [T_W-1:0] r_near;
    logic signed [T_W-1:0] r_far;
    logic                 r_miss;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [ID_BITS-1:0]    r_out_id;
    logic [COORD_BITS-2:0] r_out_dist;

    logic                  w_cfg_wr, w_box_acc, w_out_free, w_ray_ok, w_hit;
    logic [MAG_BITS-1:0]   w_a [3];
    logic [1:0]            w_sax, w_pax;
    t_coord                w_corner;
    logic signed [COORD_BITS:0] w_diff;
    logic [MUL_W-1:0]      w_dmag, w_mul_a, w_mul_b;
    logic [SUM_W-1:0]      w_rb;
    logic [T_W-1:0]        w_p;
    logic signed [T_W-1:0] w_t, w_lower, w_upper;
    logic [DVD_W-1:0]      w_dvd, w_quot;
    logic [DVS_W-1:0]      w_dvs;
    logic                  w_div_done;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && (i_cfg.reg_index <= REG_MAX_DIST);
    assign i_box.ready = i_cmd.box_rdy;
    assign w_box_acc   = i_box.valid && i_cmd.box_rdy;
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k] = r_dir[k][COORD_BITS-1] ? MAG_BITS'(-r_dir[k]) : MAG_BITS'(r_dir[k]);
        end
    end

    assign w_ray_ok = (r_max > 0) && (r_sum != '0);

    assign w_sax    = i_cmd.mul_idx[2:1];
    assign w_corner = i_cmd.mul_idx[0] ? r_hi[w_sax] : r_lo[w_sax];
    assign w_diff   = {w_corner[COORD_BITS-1], w_corner}
                    - {r_org[w_sax][COORD_BITS-1], r_org[w_sax]};
    assign w_dmag   = w_diff[COORD_BITS] ? MUL_W'(-w_diff) : MUL_W'(w_diff);
    assign w_mul_a  = i_cmd.mul_slab ? w_dmag : {1'b0, w_a[i_cmd.mul_idx[1:0]]};
    assign w_mul_b  = i_cmd.mul_slab ? r_inv[w_sax] : {1'b0, w_a[i_cmd.mul_idx[1:0]]};

    assign w_rb = r_sq_r + r_sq_bit;

    assign w_pax   = i_cmd.proc_idx[2:1];
    assign w_p     = (|r_prod[PROD_W-1:PROD_W-2]) ? T_CAP : {16'd0, r_prod[T_W-1:16]};
    assign w_t     = r_tneg ? -$signed(w_p) : $signed(w_p);
    assign w_lower = (r_t1 < w_t) ? r_t1 : w_t;
    assign w_upper = (r_t1 < w_t) ? w_t : r_t1;
    assign w_hit   = w_ray_ok && !r_miss && (r_near <= r_far);

    assign w_dvd = i_cmd.div_inv ? INV_NUM : {w_a[i_cmd.div_ax], 16'd0};
    assign w_dvs = i_cmd.div_inv ? DVS_W'(r_u[i_cmd.div_ax]) : r_sq_r[DVS_W-1:0];

    rbnh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // configuration and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_dir[0]  <= '0;
            r_dir[1]  <= '0;
            r_dir[2]  <= RST_DIR_Z;
            r_max     <= RST_MAX_DIST;
            r_best    <= RST_MAX_DIST;
            r_best_id <= '0;
            r_any     <= 1'b0;
        end else if (w_cfg_wr) begin
            case (i_cfg.reg_index)
                REG_ORIGIN_X: r_org[0] <= i_cfg.wr_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg.wr_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg.wr_data;
                REG_DIR_X:    r_dir[0] <= i_cfg.wr_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg.wr_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg.wr_data;
                REG_MAX_DIST: r_max    <= i_cfg.wr_data;
                default: ;
            endcase
            r_best    <= (i_cfg.reg_index == REG_MAX_DIST) ? t_coord'(i_cfg.wr_data) : r_max;
            r_best_id <= '0;
            r_any     <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_best    <= r_max;
            r_best_id <= '0;
            r_any     <= 1'b0;
        end else if (i_cmd.fin && w_hit) begin
            r_best    <= r_near[COORD_BITS-1:0];
            r_best_id <= r_id;
            r_any     <= 1'b1;
        end
    end

    // ray setup and slab datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
            r_tneg <= w_diff[COORD_BITS] ^ r_uneg[w_sax];
        end
        if (i_cmd.sq_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sq_acc) begin
            r_sum <= r_sum + r_prod[SUM_W-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_sq_n   <= r_sum;
            r_sq_r   <= '0;
            r_sq_bit <= SQRT_BIT0;
        end else if (i_cmd.sqrt_step) begin
            if (r_sq_n >= w_rb) begin
                r_sq_n <= r_sq_n - w_rb;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.u_load) begin
            r_u[i_cmd.div_ax]    <= w_quot[U_W-1:0];
            r_uneg[i_cmd.div_ax] <= r_dir[i_cmd.div_ax][COORD_BITS-1];
        end
        if (i_cmd.inv_load) begin
            r_inv[i_cmd.div_ax] <= w_quot[INV_W-1:0];
        end
        if (w_box_acc) begin
            r_id    <= i_box.box_id;
            r_last  <= i_box.last_box;
            r_lo[0] <= i_box.box_min_x;
            r_lo[1] <= i_box.box_min_y;
            r_lo[2] <= i_box.box_min_z;
            r_hi[0] <= i_box.box_max_x;
            r_hi[1] <= i_box.box_max_y;
            r_hi[2] <= i_box.box_max_z;
            r_near  <= '0;
            r_far   <= {{(T_W-COORD_BITS){r_best[COORD_BITS-1]}}, r_best};
            r_miss  <= 1'b0;
        end else if (i_cmd.slab_proc) begin
            if (!i_cmd.proc_idx[0]) begin
                r_t1 <= w_t;
            end else if (r_u[w_pax] == '0) begin
                if (r_org[w_pax] < r_lo[w_pax] || r_org[w_pax] > r_hi[w_pax]) begin
                    r_miss <= 1'b1;
                end
            end else begin
                if (w_lower > r_near) begin
                    r_near <= w_lower;
                end
                if (w_upper < r_far) begin
                    r_far <= w_upper;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_hit  <= r_any;
            r_out_id   <= r_any ? r_best_id : '0;
            r_out_dist <= r_any ? r_best[COORD_BITS-2:0] : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.hit_found    = r_out_hit;
    assign o_res.hit_id       = r_out_id;
    assign o_res.hit_distance = r_out_dist;

    assign o_sts.cfg_wr   = w_cfg_wr;
    assign o_sts.box_acc  = w_box_acc;
    assign o_sts.div_done = w_div_done;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = w_out_free;

    `RBNH_ASSERT(a_miss_zero, (r_out_valid && !r_out_hit) |-> (r_out_id == '0 && r_out_dist == '0), "missed scan reports nonzero id or distance")
    `RBNH_ASSERT(a_best_le_max, r_best <= r_max, "best distance exceeds max distance")
    `RBNH_ASSERT(a_box_init, w_box_acc |=> (r_near == '0 && !r_miss), "box accept did not clear slab state")

endmodule

// ===== rtl/core/rbnh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbnh_ctrl
// Sequencer for ray setup, per-box slab steps and result delivery.
// ----------------------------------------------------------------------------
`include "ray_box_nearest_hit_unit_defines.svh"

module rbnh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbnh_pkg::t_sts i_sts,
    output rbnh_pkg::t_cmd o_cmd
);
    import rbnh_pkg::*;

    localparam logic [3:0] S_SQ      = 4'd0;
    localparam logic [3:0] S_SQRT_IN = 4'd1;
    localparam logic [3:0] S_SQRT    = 4'd2;
    localparam logic [3:0] S_NDIV    = 4'd3;
    localparam logic [3:0] S_NDIV_W  = 4'd4;
    localparam logic [3:0] S_IDIV    = 4'd5;
    localparam logic [3:0] S_IDIV_W  = 4'd6;
    localparam logic [3:0] S_IDLE    = 4'd7;
    localparam logic [3:0] S_BOX     = 4'd8;
    localparam logic [3:0] S_FIN     = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    localparam logic [4:0] SQ_LAST   = 5'd3;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] BOX_LAST  = 5'd6;
    localparam logic [1:0] AX_LAST   = 2'd2;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_ax, n_ax;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ax    = r_ax;
        w_cmd   = '0;
        case (r_state)
            S_SQ: begin
                w_cmd.mul_en  = (r_cnt < SQ_LAST);
                w_cmd.mul_idx = r_cnt[2:0];
                w_cmd.sq_clr  = (r_cnt == '0);
                w_cmd.sq_acc  = (r_cnt != '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_state = S_SQRT_IN;
                end
            end
            S_SQRT_IN: begin
                w_cmd.sqrt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                w_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_ax    = '0;
                    n_state = S_NDIV;
                end
            end
            S_NDIV: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_ax    = r_ax;
                n_state = S_NDIV_W;
            end
            S_NDIV_W: begin
                w_cmd.div_ax = r_ax;
                if (i_sts.div_done) begin
                    w_cmd.u_load = 1'b1;
                    if (r_ax == AX_LAST) begin
                        n_ax    = '0;
                        n_state = S_IDIV;
                    end else begin
                        n_ax    = r_ax + 1'b1;
                        n_state = S_NDIV;
                    end
                end
            end
            S_IDIV: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_inv   = 1'b1;
                w_cmd.div_ax    = r_ax;
                n_state = S_IDIV_W;
            end
            S_IDIV_W: begin
                w_cmd.div_inv = 1'b1;
                w_cmd.div_ax  = r_ax;
                if (i_sts.div_done) begin
                    w_cmd.inv_load = 1'b1;
                    if (r_ax == AX_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ax    = r_ax + 1'b1;
                        n_state = S_IDIV;
                    end
                end
            end
            S_IDLE: begin
                w_cmd.box_rdy = 1'b1;
                if (i_sts.box_acc) begin
                    n_cnt   = '0;
                    n_state = S_BOX;
                end
            end
            S_BOX: begin
                w_cmd.mul_en    = (r_cnt < BOX_LAST);
                w_cmd.mul_slab  = 1'b1;
                w_cmd.mul_idx   = r_cnt[2:0];
                w_cmd.slab_proc = (r_cnt != '0);
                w_cmd.proc_idx  = 3'(r_cnt - 1'b1);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == BOX_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_cmd.fin = 1'b1;
                n_state = i_sts.last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_SQ;
                n_cnt   = '0;
            end
        endcase
        // restart ray setup on any register write
        if (i_sts.cfg_wr) begin
            w_cmd.box_rdy = 1'b0;
            n_state = S_SQ;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SQ;
            r_cnt   <= '0;
            r_ax    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ax    <= n_ax;
        end
    end

    assign o_cmd = w_cmd;

    `RBNH_ASSERT(a_out_free, o_cmd.out_load |-> i_sts.out_free, "result loaded while output register busy")
    `RBNH_ASSERT(a_box_cnt, (r_state == S_BOX) |-> (r_cnt <= BOX_LAST), "slab step counter overran")
    `RBNH_ASSERT(a_acc_idle, i_sts.box_acc |-> (r_state == S_IDLE), "box accepted outside idle")

endmodule
